@@ rtl/vgapg_pkg.sv @@
// Shared types, constants and helper functions of the VGA planar graphics controller.
// No dependencies; every other file depends on this package.
package vgapg_pkg;

  localparam int ADDR_W = 18;
  localparam int DATA_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam int PLANES = 4;

  typedef logic [DATA_W-1:0] byte_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [PLANES-1:0] plane_mask_t;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_RESET     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EN_SET_RESET  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_ROTATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_MAP_SEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_MODE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_MASK      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_MASK      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANAR_ENABLE = 3'd7;

  localparam logic [1:0] WM_ROTATE_SR = 2'd0;
  localparam logic [1:0] WM_LATCH     = 2'd1;
  localparam logic [1:0] WM_EXPAND    = 2'd2;
  localparam logic [1:0] WM_MASKED_SR = 2'd3;

  localparam logic [1:0] LF_NONE = 2'd0;
  localparam logic [1:0] LF_AND  = 2'd1;
  localparam logic [1:0] LF_OR   = 2'd2;
  localparam logic [1:0] LF_XOR  = 2'd3;

  function automatic byte_t rotr8(input byte_t v, input logic [2:0] n);
    logic [2*DATA_W-1:0] dbl;
    dbl = {v, v} >> n;
    return dbl[DATA_W-1:0];
  endfunction

  function automatic byte_t lf_apply(input logic [1:0] fn, input byte_t v, input byte_t latch);
    byte_t res;
    case (fn)
      LF_AND:  res = v & latch;
      LF_OR:   res = v | latch;
      LF_XOR:  res = v ^ latch;
      default: res = v;
    endcase
    return res;
  endfunction

endpackage

@@ rtl/vgapg_if.sv @@
// Valid/ready channel interfaces: CPU access request and read response.
// Depends on vgapg_pkg for field widths.
interface vgapg_req_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [vgapg_pkg::ADDR_W-1:0] address;
  logic [vgapg_pkg::DATA_W-1:0] data;

  modport source (output valid, mode, address, data, input ready);
  modport sink (input valid, mode, address, data, output ready);
endinterface

interface vgapg_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [vgapg_pkg::DATA_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

@@ rtl/vga_planar_graphics_controller.sv @@
// VGA planar graphics controller: CPU reads and writes of video memory, linear or planar.
// Depends on vgapg_pkg and the channel interfaces in vgapg_if.sv.
//
// One access is in flight at a time. After the request transfer the address is split into a
// plane offset and the lane of the addressed byte by a reciprocal multiplication. In S_DIV
// the quotient is registered first, then the address less quotient times PLANE_BYTES.
// S_MEM then drives the single port of the video memory (four byte lanes, one per plane,
// one word per plane offset), and S_DONE forms the result and loads the response
// register. A new request transfer is accepted only in S_IDLE, once the response is loaded.
// A response that is not yet taken stalls the next item in its completion cycle.
// Video memory has no reset; plane latches, configuration, state, lane and valid flag clear
// on reset.
module vga_planar_graphics_controller #(
  parameter int PLANE_BYTES = 65536
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [vgapg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vgapg_pkg::CFG_DATA_W-1:0]   cfg_data,
  vgapg_req_if.sink                          in_bus,
  vgapg_rsp_if.source                        out_bus
);
  import vgapg_pkg::*;

  localparam int QMAX   = ((1 << ADDR_W) - 1) / PLANE_BYTES;
  localparam int NSTEP  = $clog2(QMAX + 1);
  localparam int OW     = $clog2(PLANE_BYTES);
  localparam int RSHIFT = ADDR_W + OW;
  localparam int PW     = 2 * ADDR_W + 1;
  localparam logic [ADDR_W:0] RECIP = (ADDR_W + 1)'(
    ((64'd1 << RSHIFT) + 64'(PLANE_BYTES) - 64'd1) / 64'(PLANE_BYTES));
  localparam addr_t PB_A = addr_t'(PLANE_BYTES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_MEM  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [3:0] set_reset_r;
  logic [3:0] en_set_reset_r;
  logic [4:0] data_rotate_r;
  logic [1:0] read_map_sel_r;
  logic [1:0] write_mode_r;
  byte_t      bit_mask_r;
  logic [3:0] map_mask_r;
  logic       planar_r;

  logic [1:0]       state_r;
  logic             item_mode_r;
  byte_t            item_data_r;
  addr_t            rem_r;
  addr_t            rem_nxt;
  logic [1:0]       bank_r;
  logic             div_phase_r;
  logic [NSTEP-1:0] quot_r;
  logic [NSTEP-1:0] quot_calc;
  logic [PW-1:0]    quot_prod;
  byte_t            latch_r [PLANES];
  logic             out_valid_r;
  byte_t            out_data_r;
  logic             rsp_load;

  logic [PLANES-1:0][DATA_W-1:0] vmem [PLANE_BYTES];
  logic [PLANES-1:0][DATA_W-1:0] mem_q_r;
  logic [PLANES-1:0][DATA_W-1:0] mem_wdata;
  plane_mask_t                   mem_be;
  logic                          mem_re;
  logic                          mem_we;
  logic [OW-1:0]                 mem_addr;

  byte_t plane_val [PLANES];
  byte_t rot_data;
  byte_t rd_result;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_reset_r    <= '0;
      en_set_reset_r <= '0;
      data_rotate_r  <= '0;
      read_map_sel_r <= '0;
      write_mode_r   <= '0;
      bit_mask_r     <= '0;
      map_mask_r     <= '0;
      planar_r       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SET_RESET:     set_reset_r    <= cfg_data[3:0];
        CFG_EN_SET_RESET:  en_set_reset_r <= cfg_data[3:0];
        CFG_DATA_ROTATE:   data_rotate_r  <= cfg_data[4:0];
        CFG_READ_MAP_SEL:  read_map_sel_r <= cfg_data[1:0];
        CFG_WRITE_MODE:    write_mode_r   <= cfg_data[1:0];
        CFG_BIT_MASK:      bit_mask_r     <= cfg_data[7:0];
        CFG_MAP_MASK:      map_mask_r     <= cfg_data[3:0];
        CFG_PLANAR_ENABLE: planar_r       <= cfg_data[0];
      endcase
    end
  end

  assign in_bus.ready      = (state_r == S_IDLE);
  assign out_bus.valid     = out_valid_r;
  assign out_bus.read_data = out_data_r;

  // Quotient by reciprocal, then remainder
  assign quot_prod = PW'(rem_r) * PW'(RECIP);
  assign quot_calc = quot_prod[RSHIFT +: NSTEP];
  assign rem_nxt   = rem_r - addr_t'(quot_r) * PB_A;

  // Write data per plane
  assign rot_data = rotr8(item_data_r, data_rotate_r[2:0]);

  always_comb begin
    byte_t v;
    byte_t sr;
    byte_t sel;
    for (int p = 0; p < PLANES; p++) begin
      sr  = {DATA_W{set_reset_r[p]}};
      sel = rot_data & bit_mask_r;
      v   = latch_r[p];
      case (write_mode_r)
        WM_ROTATE_SR: begin
          v = en_set_reset_r[p] ? sr : rot_data;
          v = lf_apply(data_rotate_r[4:3], v, latch_r[p]);
          v = (bit_mask_r & v) | (~bit_mask_r & latch_r[p]);
        end
        WM_LATCH: begin
          v = latch_r[p];
        end
        WM_EXPAND: begin
          v = lf_apply(data_rotate_r[4:3], {DATA_W{item_data_r[p]}}, latch_r[p]);
          v = (bit_mask_r & v) | (~bit_mask_r & latch_r[p]);
        end
        default: begin
          v = (sel & sr) | (~sel & latch_r[p]);
        end
      endcase
      plane_val[p] = v;
    end
  end

  // Map planes onto memory lanes
  always_comb begin
    logic [1:0] lane_plane;
    for (int l = 0; l < PLANES; l++) begin
      lane_plane = 2'(l) - bank_r;
      if (planar_r) begin
        mem_wdata[l] = plane_val[lane_plane];
        mem_be[l]    = map_mask_r[lane_plane];
      end else begin
        mem_wdata[l] = item_data_r;
        mem_be[l]    = (bank_r == 2'(l));
      end
    end
  end

  assign mem_addr = rem_r[OW-1:0];
  assign mem_re   = (state_r == S_MEM) && (item_mode_r == MODE_READ);
  assign mem_we   = (state_r == S_MEM) && (item_mode_r == MODE_WRITE);

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q_r <= vmem[mem_addr];
    end
    for (int b = 0; b < PLANES; b++) begin
      if (mem_we && mem_be[b]) begin
        vmem[mem_addr][b] <= mem_wdata[b];
      end
    end
  end

  assign rd_result = planar_r ? mem_q_r[bank_r + read_map_sel_r] : mem_q_r[bank_r];
  assign rsp_load  = (state_r == S_DONE) && (!out_valid_r || out_bus.ready);

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      div_phase_r <= 1'b0;
      bank_r      <= '0;
      for (int p = 0; p < PLANES; p++) begin
        latch_r[p] <= '0;
      end
    end else begin
      if (rsp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_bus.valid) begin
            item_mode_r <= in_bus.mode;
            item_data_r <= in_bus.data;
            rem_r       <= in_bus.address;
            div_phase_r <= 1'b0;
            state_r     <= S_DIV;
          end
        end
        S_DIV: begin
          if (!div_phase_r) begin
            quot_r      <= quot_calc;
            div_phase_r <= 1'b1;
          end else begin
            rem_r   <= rem_nxt;
            bank_r  <= quot_r[1:0];
            state_r <= S_MEM;
          end
        end
        S_MEM: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            out_data_r <= (item_mode_r == MODE_WRITE) ? '0 : rd_result;
            if (item_mode_r == MODE_READ && planar_r) begin
              for (int p = 0; p < PLANES; p++) begin
                latch_r[p] <= mem_q_r[bank_r + 2'(p)];
              end
            end
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.valid && in_bus.ready |=> state_r == S_DIV)
    else $error("request transfer did not start address reduction");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("response raised outside completion");

  a_mem_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !mem_re && state_r == S_MEM)
    else $error("memory written outside access cycle");

  a_write_rsp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && item_mode_r == MODE_WRITE && (!out_valid_r || out_bus.ready)
    |=> out_valid_r && out_data_r == '0)
    else $error("write response not zero");

endmodule
